// ===== rtl/line_substring_matcher_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the line substring matcher checker
// ---------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_MATCHER_MACROS_SVH
`define LINE_SUBSTRING_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lsm_pkg.sv =====
// ---------------------------------------------------------------------------
// lsm_pkg
// Types, codes and helpers shared by the line substring matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

	// Request codes carried in req_type
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_TEXT = 2'd1;
	localparam logic [1:0] REQ_EOF  = 2'd2;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_PATTERN_LENGTH   = 2'd0;
	localparam logic [1:0] REG_FOLD_CASE        = 2'd1;
	localparam logic [1:0] REG_SHOW_LINE_NUMBER = 2'd2;

	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// Input word
	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] pattern_index;
		logic [7:0] byte_value;
	} req_t;

	// Result word
	typedef struct packed {
		logic [31:0] line_number;
		logic        matched;
	} res_t;

	// Configuration registers
	typedef struct packed {
		logic [7:0] pattern_length;
		logic       fold_case;
		logic       show_line_number;
	} cfg_t;

	// Committed operation handed to the match datapath
	typedef struct packed {
		logic       load_en;
		logic       shift_en;
		logic [6:0] idx;
		logic [7:0] data;
	} lsm_op_t;

	// Fold ASCII upper case to lower case when enabled
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ic);
		logic [7:0] r;
		r = b;
		if (ic && (b inside {[8'h41:8'h5A]})) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lsm_cfg.sv =====
// ---------------------------------------------------------------------------
// lsm_cfg
// APB register block: pattern length, case folding and line number enable.
// ---------------------------------------------------------------------------
`default_nettype none

module lsm_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lsm_pkg::APB_AW-1:0] paddr,
	input  wire logic [lsm_pkg::APB_DW-1:0] pwdata,
	output logic      [lsm_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	output lsm_pkg::cfg_t                   cfg,
	output logic                            len_wr
);
	import lsm_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign len_wr  = wr_en && (reg_idx == REG_PATTERN_LENGTH);
	assign cfg     = cfg_q;

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PATTERN_LENGTH:   cfg_q.pattern_length   <= pwdata[7:0];
				REG_FOLD_CASE:        cfg_q.fold_case        <= pwdata[0];
				REG_SHOW_LINE_NUMBER: cfg_q.show_line_number <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_PATTERN_LENGTH:   prdata = APB_DW'(cfg_q.pattern_length);
			REG_FOLD_CASE:        prdata = APB_DW'(cfg_q.fold_case);
			REG_SHOW_LINE_NUMBER: prdata = APB_DW'(cfg_q.show_line_number);
			default:              prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/lsm_match.sv =====
// ---------------------------------------------------------------------------
// lsm_match
// Pattern store, end-aligned pattern copy, text window and full compare.
// ---------------------------------------------------------------------------
`default_nettype none

module lsm_match #(
	parameter int unsigned PATTERN_MAX = 128,
	parameter int unsigned LW          = $clog2(PATTERN_MAX + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lsm_pkg::lsm_op_t op,
	input  wire logic [LW-1:0]   len,
	input  wire logic            fold_case,
	input  wire logic            len_wr,
	output logic                 win_hit
);
	import lsm_pkg::*;

	localparam int unsigned IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int unsigned XW = (LW > 7) ? LW : 7;

	logic [7:0] store_q [PATTERN_MAX];
	logic [7:0] store_n [PATTERN_MAX];
	logic [7:0] apat_q  [PATTERN_MAX];
	logic [7:0] win_q   [PATTERN_MAX];
	logic [7:0] win_n   [PATTERN_MAX];

	logic [8*PATTERN_MAX-1:0] rev_flat;
	logic [8*PATTERN_MAX-1:0] align_flat;
	logic [LW-1:0]            shamt;
	logic [XW-1:0]            idx_x;
	logic [XW-1:0]            len_x;
	logic [XW-1:0]            wpos;
	logic                     idx_ok;
	logic                     idx_in_len;
	logic                     realign_q;
	logic [PATTERN_MAX-1:0]   eq;

	assign idx_x      = XW'(op.idx);
	assign len_x      = XW'(len);
	assign idx_ok     = idx_x < XW'(PATTERN_MAX);
	assign idx_in_len = idx_x < len_x;
	assign wpos       = len_x - idx_x - XW'(1);

	// Store contents after this cycle's load
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			store_n[i] = store_q[i];
		end
		if (op.load_en && idx_ok) begin
			store_n[IW'(op.idx)] = op.data;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			store_q[i] <= store_n[i];
		end
	end

	// Reverse the store and shift so that the last pattern byte lands at slot zero
	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			rev_flat[8*j +: 8] = store_n[PATTERN_MAX-1-j];
		end
	end

	assign shamt      = LW'(PATTERN_MAX) - len;
	assign align_flat = rev_flat >> {shamt, 3'b000};

	// Realign in the cycle after a length write, else patch the loaded byte in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			realign_q <= 1'b0;
		end else begin
			realign_q <= len_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (realign_q) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				apat_q[k] <= align_flat[8*k +: 8];
			end
		end else if (op.load_en && idx_in_len) begin
			apat_q[IW'(wpos)] <= op.data;
		end
	end

	// Window with the incoming byte at slot zero
	always_comb begin
		win_n[0] = op.data;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_n[k] = win_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= '0;
			end
		end else if (op.shift_en) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= win_n[k];
			end
		end
	end

	// Compare every slot in use
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cmp
		assign eq[k] = (LW'(k) >= len) ||
			(fold_byte(win_n[k], fold_case) == fold_byte(apat_q[k], fold_case));
	end

	assign win_hit = &eq;

endmodule

`default_nettype wire

// ===== rtl/line_substring_matcher.sv =====
// ---------------------------------------------------------------------------
// line_substring_matcher
// Fixed-string line matcher over a byte stream, one result word per closed line or chunk.
// ---------------------------------------------------------------------------
// Takes one input word per clock unless stalled: a pattern byte load, a text
// byte or end of file. An accepted word is held in the input register, where
// the whole window of recent text is compared against the stored pattern in
// one pass, and a closed line is written from there to the result register.
// Throughput is one word per cycle for as long as the result side takes its
// words; a result that waits stalls the input only when the next word also
// closes a line. A write to the pattern length register rebuilds the
// end-aligned pattern copy in the cycle after the write.
`default_nettype none

module line_substring_matcher #(
	parameter int unsigned PATTERN_MAX = 128,
	parameter int unsigned LINE_CHUNK  = 501
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire lsm_pkg::req_t              req,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output lsm_pkg::res_t                   res,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lsm_pkg::APB_AW-1:0] paddr,
	input  wire logic [lsm_pkg::APB_DW-1:0] pwdata,
	output logic      [lsm_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);
	import lsm_pkg::*;

	localparam int unsigned LW   = $clog2(PATTERN_MAX + 1);
	localparam int unsigned CW   = $clog2(LINE_CHUNK + 1);
	localparam int unsigned CMPW = (CW > LW) ? CW : LW;
	localparam int unsigned PLW  = (LW > 8) ? LW : 8;

	cfg_t          cfg;
	logic          len_wr;
	logic [LW-1:0] len_used;
	logic [PLW-1:0] pl_ext;

	logic          valid_s1;
	req_t          req_s1;
	logic [CW-1:0] cnt_q;
	logic [31:0]   line_q;
	logic          match_q;
	res_t          res_q;
	logic          res_valid_q;

	logic          is_load;
	logic          is_text;
	logic          is_eof;
	logic [CW-1:0] cnt_inc;
	logic          win_hit;
	logic          hit;
	logic          seen_now;
	logic          close_text;
	logic          close_eof;
	logic          emit;
	logic          s1_go;
	logic          commit;
	logic [31:0]   line_next;
	res_t          res_d;
	lsm_op_t       op;

	lsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.len_wr  (len_wr)
	);

	// Clamp the pattern length to the store depth
	assign pl_ext   = PLW'(cfg.pattern_length);
	assign len_used = (pl_ext > PLW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(pl_ext);

	// Decode the word in the input register
	assign is_load = valid_s1 && (req_s1.req_type == REQ_LOAD);
	assign is_text = valid_s1 && (req_s1.req_type == REQ_TEXT);
	assign is_eof  = valid_s1 && (req_s1.req_type == REQ_EOF);

	assign cnt_inc  = cnt_q + CW'(1);
	assign hit      = is_text && (len_used != '0) &&
		(CMPW'(cnt_inc) >= CMPW'(len_used)) && win_hit;
	assign seen_now = match_q || hit;

	assign close_text = is_text &&
		((req_s1.byte_value == CHAR_NEWLINE) || (cnt_inc == CW'(LINE_CHUNK)));
	assign close_eof  = is_eof && (cnt_q != '0);
	assign emit       = close_text || close_eof;

	// Advance unless a result must be written while the result register is held
	assign s1_go     = !emit || !res_valid_q || res_ready;
	assign req_ready = !valid_s1 || s1_go;
	assign commit    = valid_s1 && s1_go;

	assign op.load_en  = commit && is_load;
	assign op.shift_en = commit && is_text;
	assign op.idx      = req_s1.pattern_index;
	assign op.data     = req_s1.byte_value;

	lsm_match #(
		.PATTERN_MAX (PATTERN_MAX),
		.LW          (LW)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.len         (len_used),
		.fold_case   (cfg.fold_case),
		.len_wr      (len_wr),
		.win_hit     (win_hit)
	);

	assign line_next = (line_q == '1) ? line_q : (line_q + 32'd1);

	// Form the result word
	always_comb begin
		res_d.line_number = cfg.show_line_number ? line_q : '0;
		res_d.matched     = (is_text ? seen_now : match_q) || (len_used == '0);
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// Line state: byte count, sticky match and line number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			match_q <= 1'b0;
			line_q  <= 32'd1;
		end else if (commit) begin
			if (is_text) begin
				if (close_text) begin
					cnt_q   <= '0;
					match_q <= 1'b0;
					line_q  <= line_next;
				end else begin
					cnt_q   <= cnt_inc;
					match_q <= seen_now;
				end
			end else if (is_eof) begin
				cnt_q   <= '0;
				match_q <= 1'b0;
				line_q  <= 32'd1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== rtl/lsm_checker.sv =====
// ---------------------------------------------------------------------------
// lsm_checker
// Port-level checks on the result channel against the written configuration.
// ---------------------------------------------------------------------------
`default_nettype none

`include "line_substring_matcher_macros.svh"

module lsm_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       res_valid,
	input wire logic                       res_ready,
	input wire lsm_pkg::res_t              res,
	input wire logic                       psel,
	input wire logic                       penable,
	input wire logic                       pwrite,
	input wire logic [lsm_pkg::APB_AW-1:0] paddr,
	input wire logic [lsm_pkg::APB_DW-1:0] pwdata,
	input wire logic                       pready
);
	import lsm_pkg::*;

	logic [7:0] len_sh_q;
	logic       show_sh_q;
	logic       cfg_wr;

	assign cfg_wr = psel && penable && pwrite && pready;

	// Track the written configuration from the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_sh_q  <= '0;
			show_sh_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PATTERN_LENGTH:   len_sh_q  <= pwdata[7:0];
				REG_SHOW_LINE_NUMBER: show_sh_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	`LSM_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready,
		res_valid && $stable(res), "result word changed while stalled")

	`LSM_ASSERT_NOW(a_empty_matches, clk, arst_n, res_valid && (len_sh_q == 8'd0),
		res.matched, "empty pattern reported a line without match")

	`LSM_ASSERT_NOW(a_hidden_line, clk, arst_n, res_valid && !show_sh_q,
		res.line_number == 32'd0, "line number shown while disabled")

	`LSM_ASSERT_NOW(a_shown_line, clk, arst_n, res_valid && show_sh_q,
		res.line_number != 32'd0, "line number zero while enabled")

endmodule

bind line_substring_matcher lsm_checker u_lsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.pready    (pready)
);

`default_nettype wire

// ===== dv/line_substring_matcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_substring_matcher_test
// Self-checking bench for the grep-style line matcher. A short scripted
// sequence covers reset behaviour, the empty pattern, case folding and end of
// file. Randomised phases then stream lines, some with the pattern planted,
// under several register settings. Every result word is scored against an
// in-bench model of the line/match state.
// ----------------------------------------------------------------------------
module line_substring_matcher_test;
	import lsm_pkg::*;

	localparam int unsigned PAT_MAX    = 128;
	localparam int unsigned CHUNK_MAX  = 501;
	localparam int unsigned LONG_HOLD  = 400;
	localparam int unsigned SETTLE     = 4;
	localparam int unsigned REPORT_MAX = 10;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// After reset the line number is hidden and an empty pattern hits every line
	localparam res_t HIDDEN_HIT = '{line_number: 32'd0, matched: 1'b1};

	typedef enum int unsigned {TAKE_ALL, TAKE_HALF, TAKE_MOST, TAKE_FEW} stall_mode_e;

	typedef struct {
		bit         is_reg;
		logic [1:0] sel;
		logic [7:0] val;
		req_t       w;
		bit         typed;
		res_t       want;
	} step_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req       = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	res_t              res;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [APB_AW-1:0] paddr     = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// Model of the matcher state and registers
	logic [7:0]  pat_bytes [PAT_MAX];
	logic [7:0]  text_win [PAT_MAX];
	int unsigned win_pos;
	int unsigned chunk_fill;
	logic [31:0] line_no;
	bit          hit_seen;
	logic [7:0]  cfg_len;
	bit          cfg_fold;
	bit          cfg_show;

	res_t        pending_lines [$];
	step_row_t   script [$];
	int unsigned words_sent    = 0;
	int unsigned burst_left    = 0;
	int unsigned lines_checked = 0;
	int unsigned lines_hit     = 0;
	int unsigned line_faults   = 0;
	int unsigned long_holds    = 0;
	int unsigned hold_mark     = 0;
	bit          hold_req      = 1'b0;

	line_substring_matcher #(
		.PATTERN_MAX(PAT_MAX),
		.LINE_CHUNK (CHUNK_MAX)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		if (cfg_fold && b >= 8'h41 && b <= 8'h5A)
			return b + 8'h20;
		return b;
	endfunction

	function automatic int unsigned active_len();
		return (cfg_len > PAT_MAX) ? PAT_MAX : int'(cfg_len);
	endfunction

	// Report the open line and start a fresh one
	function automatic void close_line(output res_t line_out);
		line_out.line_number = cfg_show ? line_no : 32'd0;
		line_out.matched     = hit_seen || (active_len() == 0);
		if (line_no != 32'hFFFF_FFFF)
			line_no++;
		chunk_fill = 0;
		hit_seen   = 1'b0;
	endfunction

	// Advance the model by one input word; returns 1 when a line closes
	function automatic bit grep_predict(input req_t w, output res_t line_out);
		int unsigned len;
		int unsigned first;
		bit          same;
		bit          got;
		line_out = '0;
		got      = 1'b0;
		case (w.req_type)
			REQ_LOAD: begin
				pat_bytes[w.pattern_index] = w.byte_value;
			end
			REQ_TEXT: begin
				len = active_len();
				text_win[win_pos] = w.byte_value;
				win_pos = (win_pos + 1) % PAT_MAX;
				chunk_fill++;
				if (len > 0 && chunk_fill >= len) begin
					first = (win_pos + PAT_MAX - len) % PAT_MAX;
					same  = 1'b1;
					for (int unsigned i = 0; i < len; i++)
						if (to_lower(text_win[(first + i) % PAT_MAX]) != to_lower(pat_bytes[i]))
							same = 1'b0;
					if (same)
						hit_seen = 1'b1;
				end
				if (w.byte_value == CHAR_NEWLINE || chunk_fill >= CHUNK_MAX) begin
					close_line(line_out);
					got = 1'b1;
				end
			end
			REQ_EOF: begin
				if (chunk_fill > 0) begin
					close_line(line_out);
					got = 1'b1;
				end
				line_no    = 32'd1;
				chunk_fill = 0;
				hit_seen   = 1'b0;
			end
			default: ;
		endcase
		return got;
	endfunction

	function automatic req_t mk_word(input logic [1:0] kind, input logic [6:0] idx,
			input logic [7:0] b);
		req_t w;
		w.req_type      = kind;
		w.pattern_index = idx;
		w.byte_value    = b;
		return w;
	endfunction

	function automatic void add_word(input logic [1:0] kind, input logic [6:0] idx,
			input logic [7:0] b, input bit typed = 1'b0, input res_t want = '0);
		step_row_t r;
		r.is_reg = 1'b0;
		r.sel    = '0;
		r.val    = '0;
		r.w      = mk_word(kind, idx, b);
		r.typed  = typed;
		r.want   = want;
		script.push_back(r);
	endfunction

	function automatic void add_reg(input logic [1:0] sel, input logic [7:0] val);
		step_row_t r;
		r.is_reg = 1'b1;
		r.sel    = sel;
		r.val    = val;
		r.w      = '0;
		r.typed  = 1'b0;
		r.want   = '0;
		script.push_back(r);
	endfunction

	// Text bytes lean on a few letters so partial and folded matches are common
	function automatic logic [7:0] text_char();
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 55) begin
			case ($urandom_range(4, 0))
				0: return 8'h61;
				1: return 8'h41;
				2: return 8'h62;
				3: return 8'h42;
				default: return 8'h00;
			endcase
		end
		if (r < 85)
			return 8'h41 + 8'($urandom_range(25, 0)) + ($urandom_range(1, 0) ? 8'h20 : 8'h00);
		return 8'($urandom_range(255, 0));
	endfunction

	function automatic logic [7:0] pattern_char();
		logic [7:0] b;
		do
			b = text_char();
		while (b == CHAR_NEWLINE);
		return b;
	endfunction

	// Offer one word in bursts with random gaps; score it once taken
	task automatic send_word(input req_t w, input bit use_want = 1'b0,
			input res_t want = '0);
		res_t        line_out;
		int unsigned gap;
		bit          closes;
		if (burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 100)
				: $urandom_range(40, 1);
		end
		burst_left--;
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		closes = grep_predict(w, line_out);
		if (use_want)
			pending_lines.push_back(want);
		else if (closes)
			pending_lines.push_back(line_out);
		if (w.req_type != REQ_UNKNOWN)
			words_sent++;
	endtask

	// Hold the input until every expected line is back, then let the pipe settle
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_lines.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] sel, input logic [7:0] val);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (sel)
			REG_PATTERN_LENGTH:   cfg_len  = val;
			REG_FOLD_CASE:        cfg_fold = val[0];
			REG_SHOW_LINE_NUMBER: cfg_show = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// One line of text, sometimes carrying the pattern, closed in a random way
	task automatic emit_line(input int unsigned lo, input int unsigned hi, input bit straddle);
		int unsigned n;
		int unsigned len;
		int unsigned at;
		int unsigned ending;
		bit          plant;
		bit          mangle;
		logic [7:0]  b;
		n      = $urandom_range(hi, lo);
		len    = active_len();
		plant  = (len > 0) && (n >= len) && ($urandom_range(2, 0) != 0);
		mangle = ($urandom_range(2, 0) == 0);
		at     = 0;
		if (plant)
			at = (straddle && $urandom_range(1, 0)) ? CHUNK_MAX + 1 - len
				: $urandom_range(n - len, 0);
		for (int unsigned i = 0; i < n; i++) begin
			if (plant && i >= at && i < at + len) begin
				b = pat_bytes[i - at];
				if (mangle && $urandom_range(1, 0) &&
						((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)))
					b ^= 8'h20;
			end else begin
				b = text_char();
			end
			send_word(mk_word(REQ_TEXT, 7'($urandom_range(127, 0)), b));
		end
		ending = $urandom_range(9, 0);
		if (ending != 8)
			send_word(mk_word(REQ_TEXT, 7'd0, CHAR_NEWLINE));
		if (ending >= 8)
			send_word(mk_word(REQ_EOF, 7'($urandom_range(127, 0)), 8'($urandom_range(255, 0))));
	endtask

	// Stray words between lines: pattern rewrites, unknown requests, bare end of file or short runs of random text bytes
	task automatic send_noise();
		case ($urandom_range(4, 0))
			0: send_word(mk_word(REQ_LOAD, 7'($urandom_range(127, 0)),
				8'($urandom_range(255, 0))));
			1: send_word(mk_word(REQ_UNKNOWN, 7'($urandom_range(127, 0)),
				8'($urandom_range(255, 0))));
			2: send_word(mk_word(REQ_EOF, 7'($urandom_range(127, 0)),
				8'($urandom_range(255, 0))));
			default: begin
				repeat ($urandom_range(4, 1))
					send_word(mk_word(REQ_TEXT, 7'($urandom_range(127, 0)),
						8'($urandom_range(255, 0))));
			end
		endcase
	endtask

	task automatic run_phase(input logic [7:0] plen, input bit fold, input bit show,
			input int unsigned lo, input int unsigned hi, input int unsigned budget,
			input bit long_line);
		int unsigned stop_at;
		int unsigned len;
		stop_at = words_sent + budget;
		write_reg(REG_PATTERN_LENGTH, plen);
		write_reg(REG_FOLD_CASE, {7'd0, fold});
		write_reg(REG_SHOW_LINE_NUMBER, {7'd0, show});
		// refresh the bytes in use
		len = active_len();
		for (int unsigned i = 0; i < len; i++)
			send_word(mk_word(REQ_LOAD, 7'(i), pattern_char()));
		if (long_line)
			emit_line(CHUNK_MAX + 1, CHUNK_MAX + 60, 1'b1);
		while (words_sent < stop_at) begin
			if ($urandom_range(99, 0) < 85)
				emit_line(lo, hi, 1'b0);
			else
				send_noise();
		end
	endtask

	// Score each result word against the oldest expectation
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_lines.size() == 0) begin
				if (line_faults < REPORT_MAX)
					$display("%0t: unexpected result word: line %0d matched %0b",
						$time, res.line_number, res.matched);
				line_faults++;
			end else begin
				want = pending_lines.pop_front();
				lines_checked++;
				if (want.matched)
					lines_hit++;
				if (res.line_number !== want.line_number || res.matched !== want.matched) begin
					if (line_faults < REPORT_MAX)
						$display(
							"%0t: want line %0d matched %0b, got line %0d matched %0b",
							$time, want.line_number, want.matched, res.line_number,
							res.matched);
					line_faults++;
				end
			end
		end
	end

	// Result side: stall patterns that change every so often, plus one long hold-off
	initial begin : result_side
		stall_mode_e mode;
		int unsigned span;
		mode = TAKE_ALL;
		span = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req && words_sent >= hold_mark) begin
				hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_holds++;
			end else begin
				if (span == 0) begin
					mode = stall_mode_e'($urandom_range(3, 0));
					span = $urandom_range(120, 8);
				end
				span--;
				case (mode)
					TAKE_ALL:  res_ready <= 1'b1;
					TAKE_HALF: res_ready <= 1'($urandom_range(1, 0));
					TAKE_MOST: res_ready <= ($urandom_range(4, 0) != 0);
					default:   res_ready <= ($urandom_range(3, 0) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		foreach (pat_bytes[i])
			pat_bytes[i] = 8'h00;
		foreach (text_win[i])
			text_win[i] = 8'h00;
		win_pos    = 0;
		chunk_fill = 0;
		line_no    = 32'd1;
		hit_seen   = 1'b0;
		cfg_len    = 8'd0;
		cfg_fold   = 1'b0;
		cfg_show   = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: empty pattern, hidden line numbers
		add_word(REQ_TEXT, 7'd0, 8'h78);
		add_word(REQ_TEXT, 7'd0, CHAR_NEWLINE, 1'b1, HIDDEN_HIT);
		add_word(REQ_EOF, 7'd0, 8'h00);
		add_word(REQ_TEXT, 7'h7F, 8'h00);
		add_word(REQ_TEXT, 7'd0, 8'hFF);
		add_word(REQ_EOF, 7'h7F, 8'hFF, 1'b1, HIDDEN_HIT);
		add_word(REQ_UNKNOWN, 7'h7F, 8'hFF);
		// two-byte pattern "Ab", plus the top store entry
		add_word(REQ_LOAD, 7'd0, 8'h41);
		add_word(REQ_LOAD, 7'd1, 8'h62);
		add_word(REQ_LOAD, 7'h7F, 8'h00);
		add_reg(REG_SHOW_LINE_NUMBER, 8'd1);
		add_reg(REG_PATTERN_LENGTH, 8'd2);
		// exact compare misses on case
		add_word(REQ_TEXT, 7'd0, 8'h61);
		add_word(REQ_TEXT, 7'd0, 8'h62);
		add_word(REQ_TEXT, 7'd0, CHAR_NEWLINE);
		add_reg(REG_FOLD_CASE, 8'd1);
		// folded compare hits
		add_word(REQ_TEXT, 7'd0, 8'h61);
		add_word(REQ_TEXT, 7'd0, 8'h42);
		add_word(REQ_TEXT, 7'd0, CHAR_NEWLINE);
		// line shorter than the pattern, closed by end of file
		add_word(REQ_TEXT, 7'd0, 8'h41);
		add_word(REQ_EOF, 7'd0, 8'h00);
		// numbering restarts after end of file
		add_word(REQ_TEXT, 7'd0, 8'h62);
		add_word(REQ_TEXT, 7'd0, CHAR_NEWLINE);

		foreach (script[k]) begin
			if (script[k].is_reg)
				write_reg(script[k].sel, script[k].val);
			else
				send_word(script[k].w, script[k].typed, script[k].want);
		end

		// fill the whole pattern store before any long pattern is enabled
		for (int unsigned i = 0; i < PAT_MAX; i++)
			send_word(mk_word(REQ_LOAD, 7'(i), pattern_char()));

		run_phase(8'd3, 1'b0, 1'b1, 0, 24, 260, 1'b1);
		hold_mark = words_sent + 80;
		hold_req  = 1'b1;
		run_phase(8'd1, 1'b1, 1'b1, 0, 12, 120, 1'b0);
		run_phase(8'd128, 1'b0, 1'b1, 100, 200, 200, 1'b0);
		run_phase(8'd255, 1'b1, 1'b0, 100, 160, 220, 1'b0);
		run_phase(8'd0, 1'b0, 1'b1, 0, 16, 40, 1'b0);
		run_phase(8'd6, 1'b1, 1'b1, 0, 30, 60, 1'b0);
		run_phase(8'd2, 1'b0, 1'b0, 0, 10, 40, 1'b0);

		wait_drained();
		repeat (8) @(posedge clk);

		$display("Streamed %0d words; %0d line results checked, %0d of them matches.",
			words_sent, lines_checked, lines_hit);
		$display("Pattern lengths 0 to 255, folding on and off, %0d long result hold-off(s).",
			long_holds);
		if (line_faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Drop the run if it hangs
	initial begin : watchdog
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lsm_pkg.sv
rtl/lsm_cfg.sv
rtl/lsm_match.sv
rtl/line_substring_matcher.sv
rtl/lsm_checker.sv
dv/line_substring_matcher_test.sv
